// ===== sv/assert_macros.svh =====
// Assertion macros used by the port checker file.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define TFG_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tfg_pkg.sv =====
// Package for the TCP flow grouper: sizes, payload structs, codes and
// the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package tfg_pkg;

  localparam int MAX_FLOWS    = 64;
  localparam int IDS_PER_FLOW = 256;

  localparam int FLOW_W = $clog2(MAX_FLOWS);
  localparam int USED_W = FLOW_W + 1;
  localparam int ID_W   = $clog2(IDS_PER_FLOW);
  localparam int CNT_W  = ID_W + 1;
  localparam int LIST_AW = FLOW_W + ID_W;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_JUNK       = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_LIST_FULL  = 2'd3;

  localparam logic [2:0] EMIT_JUNK  = 3'd0;
  localparam logic [2:0] EMIT_TFULL = 3'd1;
  localparam logic [2:0] EMIT_LFULL = 3'd2;
  localparam logic [2:0] EMIT_JOIN  = 3'd3;
  localparam logic [2:0] EMIT_OPEN  = 3'd4;

  typedef struct packed {
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [30:0] packet_id;
    logic        is_tcp_ipv4;
  } tfg_in_t;

  typedef struct packed {
    logic [5:0]  flow_index;
    logic [31:0] flow_id;
    logic        opened_flow;
    logic [8:0]  flow_packet_count;
    logic [1:0]  status;
  } tfg_out_t;

  typedef struct packed {
    logic       load;
    logic       key_rd;
    logic       idx_inc;
    logic       pos_load;
    logic       pos_dec;
    logic       list_rd;
    logic       list_shift;
    logic       list_put;
    logic       open;
    logic       emit;
    logic [2:0] emit_kind;
  } tfg_cmd_t;

  typedef struct packed {
    logic junk;
    logic used_zero;
    logic used_full;
    logic idx_last;
    logic hit;
    logic list_full;
    logic pos_one;
    logic greater;
    logic out_busy;
  } tfg_sts_t;

endpackage

// ===== sv/tfg_datapath.sv =====
// Datapath of the TCP flow grouper: key, count and ID memories, counters
// and the output register. Depends on tfg_pkg.
`timescale 1ns / 1ps

module tfg_datapath import tfg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tfg_in_t  in_data_i,
  input  tfg_cmd_t cmd_i,
  output tfg_sts_t sts_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output tfg_out_t out_data_o
);

  logic [31:0] key_src_mem   [MAX_FLOWS];
  logic [31:0] key_dst_mem   [MAX_FLOWS];
  logic [31:0] key_ports_mem [MAX_FLOWS];
  logic [CNT_W-1:0] cnt_mem  [MAX_FLOWS];
  logic [30:0] id_mem        [MAX_FLOWS*IDS_PER_FLOW];

  tfg_in_t          in_q;
  logic [31:0]      fid_q;
  logic [31:0]      key_src_q, key_dst_q, key_ports_q;
  logic [CNT_W-1:0] cnt_q;
  logic [30:0]      list_q;
  logic [FLOW_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [USED_W-1:0] used_q, used_d;
  logic             out_valid_q, out_valid_d;
  tfg_out_t         out_q, out_d;

  logic [CNT_W-1:0]  pos_m1;
  logic [FLOW_W-1:0] new_slot;
  logic [31:0]       fwd, rev;
  logic              cnt_we, id_we;
  logic [FLOW_W-1:0] cnt_wa;
  logic [CNT_W-1:0]  cnt_wd;
  logic [LIST_AW-1:0] id_wa;
  logic [30:0]       id_wd;

  assign pos_m1   = pos_q - CNT_W'(1);
  assign new_slot = used_q[FLOW_W-1:0];
  assign fwd      = {in_q.src_port_num, in_q.dst_port_num};
  assign rev      = {in_q.dst_port_num, in_q.src_port_num};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q  <= in_data_i;
      fid_q <= in_data_i.src_address + in_data_i.dst_address
             + {16'd0, in_data_i.src_port_num} + {16'd0, in_data_i.dst_port_num};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.open) begin
      key_src_mem[new_slot]   <= in_q.src_address;
      key_dst_mem[new_slot]   <= in_q.dst_address;
      key_ports_mem[new_slot] <= fwd;
    end
    if (cmd_i.key_rd) begin
      key_src_q   <= key_src_mem[idx_q];
      key_dst_q   <= key_dst_mem[idx_q];
      key_ports_q <= key_ports_mem[idx_q];
    end
  end

  always_comb begin
    cnt_we = cmd_i.open | cmd_i.list_put;
    cnt_wa = cmd_i.open ? new_slot : idx_q;
    cnt_wd = cmd_i.open ? CNT_W'(1) : cnt_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.key_rd) begin
      cnt_q <= cnt_mem[idx_q];
    end
  end

  always_comb begin
    id_we = cmd_i.open | cmd_i.list_shift | cmd_i.list_put;
    if (cmd_i.open) begin
      id_wa = {new_slot, ID_W'(0)};
      id_wd = in_q.packet_id;
    end else if (cmd_i.list_shift) begin
      id_wa = {idx_q, pos_q[ID_W-1:0]};
      id_wd = list_q;
    end else begin
      id_wa = {idx_q, pos_q[ID_W-1:0]};
      id_wd = in_q.packet_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[id_wa] <= id_wd;
    end
    if (cmd_i.list_rd) begin
      list_q <= id_mem[{idx_q, pos_m1[ID_W-1:0]}];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + FLOW_W'(1);
    end
    pos_d = pos_q;
    if (cmd_i.pos_load) begin
      pos_d = cnt_q;
    end else if (cmd_i.pos_dec) begin
      pos_d = pos_m1;
    end
    used_d = cmd_i.open ? used_q + USED_W'(1) : used_q;
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.emit_kind)
      EMIT_JUNK: begin
        out_d.status = ST_JUNK;
      end
      EMIT_TFULL: begin
        out_d.flow_id = fid_q;
        out_d.status  = ST_TABLE_FULL;
      end
      EMIT_LFULL: begin
        out_d.flow_index        = idx_q;
        out_d.flow_id           = fid_q;
        out_d.flow_packet_count = CNT_W'(IDS_PER_FLOW);
        out_d.status            = ST_LIST_FULL;
      end
      EMIT_JOIN: begin
        out_d.flow_index        = idx_q;
        out_d.flow_id           = fid_q;
        out_d.flow_packet_count = cnt_q + CNT_W'(1);
        out_d.status            = ST_OK;
      end
      EMIT_OPEN: begin
        out_d.flow_index        = new_slot;
        out_d.flow_id           = fid_q;
        out_d.opened_flow       = 1'b1;
        out_d.flow_packet_count = CNT_W'(1);
        out_d.status            = ST_OK;
      end
      default: begin
        out_d = '0;
      end
    endcase
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pos_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    sts_o.junk      = ~in_q.is_tcp_ipv4;
    sts_o.used_zero = used_q == '0;
    sts_o.used_full = used_q == USED_W'(MAX_FLOWS);
    sts_o.idx_last  = {1'b0, idx_q} == used_q - USED_W'(1);
    sts_o.hit       = (key_src_q == in_q.src_address && key_dst_q == in_q.dst_address &&
                       key_ports_q == fwd) ||
                      (key_src_q == in_q.dst_address && key_dst_q == in_q.src_address &&
                       key_ports_q == rev);
    sts_o.list_full = cnt_q == CNT_W'(IDS_PER_FLOW);
    sts_o.pos_one   = pos_q == CNT_W'(1);
    sts_o.greater   = list_q > in_q.packet_id;
    sts_o.out_busy  = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/tfg_ctrl.sv =====
// Controller of the TCP flow grouper: sequences search, insertion and
// flow opening. Depends on tfg_pkg.
`timescale 1ns / 1ps

module tfg_ctrl import tfg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tfg_sts_t sts_i,
  output tfg_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_KRD  = 3'd2;
  localparam logic [2:0] S_KCMP = 3'd3;
  localparam logic [2:0] S_NEW  = 3'd4;
  localparam logic [2:0] S_LRD  = 3'd5;
  localparam logic [2:0] S_LCMP = 3'd6;
  localparam logic [2:0] S_LPUT = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.junk) begin
          if (!sts_i.out_busy) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = EMIT_JUNK;
            state_d         = S_IDLE;
          end
        end else if (sts_i.used_zero) begin
          state_d = S_NEW;
        end else begin
          state_d = S_KRD;
        end
      end
      S_KRD: begin
        cmd_o.key_rd = 1'b1;
        state_d      = S_KCMP;
      end
      S_KCMP: begin
        if (sts_i.hit) begin
          if (sts_i.list_full) begin
            if (!sts_i.out_busy) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = EMIT_LFULL;
              state_d         = S_IDLE;
            end
          end else begin
            cmd_o.pos_load = 1'b1;
            state_d        = S_LRD;
          end
        end else if (!sts_i.idx_last) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_KRD;
        end else if (!sts_i.used_full) begin
          state_d = S_NEW;
        end else if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_TFULL;
          state_d         = S_IDLE;
        end
      end
      S_NEW: begin
        if (!sts_i.out_busy) begin
          cmd_o.open      = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_OPEN;
          state_d         = S_IDLE;
        end
      end
      S_LRD: begin
        cmd_o.list_rd = 1'b1;
        state_d       = S_LCMP;
      end
      S_LCMP: begin
        if (sts_i.greater) begin
          cmd_o.list_shift = 1'b1;
          cmd_o.pos_dec    = 1'b1;
          state_d          = sts_i.pos_one ? S_LPUT : S_LRD;
        end else begin
          state_d = S_LPUT;
        end
      end
      S_LPUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.list_put  = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_JOIN;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/tcp_flow_grouper.sv =====
// Channel | Direction | Payload   | Handshake
// in      | input     | tfg_in_t  | in_valid_i / in_ready_o
// out     | output    | tfg_out_t | out_valid_o / out_ready_i
//
// An item is loaded and dispatched: junk gets a junk result, else key memory
// reads and compares run slot by slot up to a hit or the last used slot. A miss
// opens a flow, or on a full table gives a table-full result; a hit on a full
// list gives a list-full result, else greater IDs are shifted up from the end
// of the list, each after an ID memory read, and the new ID is put in. Reset
// clears the slot fill count and control at once, with no clearing pass. A held
// result stalls the next result only, not the next item's acceptance.
// Top level of the TCP flow grouper; depends on tfg_pkg, tfg_ctrl, tfg_datapath.
`timescale 1ns / 1ps

module tcp_flow_grouper import tfg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tfg_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tfg_out_t out_data_o
);

  tfg_cmd_t cmd;
  tfg_sts_t sts;

  tfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tfg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/tfg_checker.sv =====
// Port checker for the TCP flow grouper, bound to the top level.
// Depends on tfg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfg_checker import tfg_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input tfg_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tfg_out_t out_data_o
);

  `TFG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped while stalled")
  `TFG_ASSERT(a_junk_zero, !(out_valid_o && out_data_o.status == ST_JUNK) || (out_data_o.flow_id == 32'd0 && out_data_o.flow_index == 6'd0 && out_data_o.flow_packet_count == 9'd0 && !out_data_o.opened_flow), "junk result not zero")
  `TFG_ASSERT(a_open_one, !(out_valid_o && out_data_o.opened_flow) || (out_data_o.flow_packet_count == 9'd1 && out_data_o.status == ST_OK), "opened flow count wrong")
  `TFG_ASSERT(a_tfull, !(out_valid_o && out_data_o.status == ST_TABLE_FULL) || (out_data_o.flow_index == 6'd0 && out_data_o.flow_packet_count == 9'd0 && !out_data_o.opened_flow), "table full result wrong")
  `TFG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "item accepted while busy")

endmodule

bind tcp_flow_grouper tfg_checker u_tfg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== test/tb_tcp_flow_grouper.sv =====
// Testbench for the TCP flow grouper: predicts each result from a local flow
// table and compares it with the block output. Depends on tfg_pkg and tcp_flow_grouper.
`timescale 1ns / 1ps

module tb_tcp_flow_grouper;
  import tfg_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  tfg_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tfg_out_t out_data_o;

  tcp_flow_grouper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  localparam int LIMIT_CYCLES = 8000000;

  logic [31:0] flow_sa   [MAX_FLOWS];
  logic [31:0] flow_da   [MAX_FLOWS];
  logic [31:0] flow_pt   [MAX_FLOWS];
  int          flow_cnt  [MAX_FLOWS];
  logic [30:0] flow_ids  [MAX_FLOWS][IDS_PER_FLOW];
  int          flows_open;

  tfg_in_t  pending_items[$];
  tfg_out_t expected_results[$];
  int       mismatches;
  int       cycles;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  bit       stim_done;
  int       stall_phase;
  int       in_sent;
  int       in_accepted = 0;

  function automatic tfg_out_t group_packet(tfg_in_t p);
    tfg_out_t r;
    logic [31:0] fid, fwd, rev;
    int pos;
    bit hit;
    r = '0;
    if (!p.is_tcp_ipv4) begin
      r.status = ST_JUNK;
      return r;
    end
    fid = p.src_address + p.dst_address + 32'(p.src_port_num) + 32'(p.dst_port_num);
    fwd = {p.src_port_num, p.dst_port_num};
    rev = {p.dst_port_num, p.src_port_num};
    r.flow_id = fid;
    for (int s = 0; s < flows_open; s++) begin
      hit = (flow_sa[s] == p.src_address && flow_da[s] == p.dst_address &&
             flow_pt[s] == fwd) ||
            (flow_sa[s] == p.dst_address && flow_da[s] == p.src_address &&
             flow_pt[s] == rev);
      if (hit) begin
        r.flow_index = 6'(s);
        if (flow_cnt[s] >= IDS_PER_FLOW) begin
          r.flow_packet_count = 9'(IDS_PER_FLOW);
          r.status = ST_LIST_FULL;
          return r;
        end
        pos = flow_cnt[s];
        while (pos > 0 && flow_ids[s][pos-1] > p.packet_id) begin
          flow_ids[s][pos] = flow_ids[s][pos-1];
          pos--;
        end
        flow_ids[s][pos] = p.packet_id;
        flow_cnt[s]++;
        r.flow_packet_count = 9'(flow_cnt[s]);
        r.status = ST_OK;
        return r;
      end
    end
    if (flows_open >= MAX_FLOWS) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    flow_sa[flows_open] = p.src_address;
    flow_da[flows_open] = p.dst_address;
    flow_pt[flows_open] = fwd;
    flow_cnt[flows_open] = 1;
    flow_ids[flows_open][0] = p.packet_id;
    r.flow_index = 6'(flows_open);
    r.opened_flow = 1'b1;
    r.flow_packet_count = 9'd1;
    r.status = ST_OK;
    flows_open++;
    return r;
  endfunction

  function automatic tfg_in_t make_packet(logic [31:0] sa, logic [31:0] da,
                                          logic [15:0] sp, logic [15:0] dp,
                                          logic [30:0] id, logic ok, bit swap);
    tfg_in_t p;
    p.src_address  = swap ? da : sa;
    p.dst_address  = swap ? sa : da;
    p.src_port_num = swap ? dp : sp;
    p.dst_port_num = swap ? sp : dp;
    p.packet_id    = id;
    p.is_tcp_ipv4  = ok;
    return p;
  endfunction

  function automatic logic [30:0] rand_id();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 7));
      1: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    logic [31:0] ksa[40], kda[40];
    logic [15:0] ksp[40], kdp[40];
    int k;
    rst_ni = 1'b0;
    flows_open = 0;
    mismatches = 0;
    stim_done = 1'b0;
    for (int s = 0; s < MAX_FLOWS; s++) flow_cnt[s] = 0;
    pending_items.push_back(make_packet('0, '0, '0, '0, '0, 1'b1, 0));
    pending_items.push_back(make_packet('0, '0, '0, '0, '0, 1'b1, 0));
    pending_items.push_back(make_packet('1, '1, '1, '1, '1, 1'b1, 0));
    pending_items.push_back(make_packet('1, '1, '1, '1, '0, 1'b1, 0));
    pending_items.push_back(make_packet('1, '1, '1, '1, '1, 1'b1, 0));
    pending_items.push_back(make_packet('1, '1, '1, '1, '1, 1'b0, 0));
    pending_items.push_back(make_packet('0, '0, '0, '0, '0, 1'b0, 0));
    pending_items.push_back(make_packet(32'h0A000001, 32'hC0A80001, 16'd80, 16'd5555,
                                        31'd10, 1'b1, 0));
    pending_items.push_back(make_packet(32'h0A000001, 32'hC0A80001, 16'd80, 16'd5555,
                                        31'd5, 1'b1, 1));
    pending_items.push_back(make_packet(32'h0A000001, 32'hC0A80001, 16'd5555, 16'd80,
                                        31'd7, 1'b1, 0));
    pending_items.push_back(make_packet(32'h0A000001, 32'hC0A80001, 16'd80, 16'd5555,
                                        31'd7, 1'b1, 0));
    pending_items.push_back(make_packet(32'h0A000001, 32'hC0A80001, 16'd80, 16'd5555,
                                        31'd6, 1'b1, 0));
    pending_items.push_back(make_packet(32'h0A000001, 32'hC0A80001, 16'd80, 16'd5555,
                                        31'd10, 1'b0, 1));
    for (int i = 0; i < 258; i++)
      pending_items.push_back(make_packet(32'h01020304, 32'h05060708, 16'd1, 16'd2,
                                          rand_id(), 1'b1, i[0]));
    for (int i = 0; i < 40; i++) begin
      ksa[i] = $urandom;
      kda[i] = $urandom;
      ksp[i] = 16'($urandom);
      kdp[i] = 16'($urandom);
    end
    for (int i = 0; i < 1300; i++) begin
      k = $urandom_range(0, 39);
      if ($urandom_range(0, 15) == 0)
        pending_items.push_back(make_packet($urandom, $urandom, 16'($urandom),
                                            16'($urandom), rand_id(),
                                            1'($urandom_range(0, 1)), 0));
      else
        pending_items.push_back(make_packet(ksa[k], kda[k], ksp[k], kdp[k], rand_id(),
                                            $urandom_range(0, 19) != 0,
                                            1'($urandom_range(0, 1))));
    end
    for (int i = 0; i < 60; i++)
      pending_items.push_back(make_packet($urandom, $urandom, 16'($urandom),
                                          16'($urandom), rand_id(), 1'b1, 0));
    stim_done = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      burst_left <= 0;
      gap_left <= 0;
      in_sent <= 0;
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_accepted == in_sent) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        in_sent <= in_sent + 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
          if (burst_left == 1) gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_results.push_back(group_packet(in_data_i));
      in_accepted++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (stall_phase == 3000) begin
        hold_left <= 6000;
        out_ready_i <= 1'b0;
      end else if (stall_phase[9]) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0) && (stall_phase[3:0] != 4'd7);
      end
    end
  end

  always @(posedge clk_i) begin
    tfg_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.flow_index !== out_data_o.flow_index ||
            exp_r.flow_id !== out_data_o.flow_id ||
            exp_r.opened_flow !== out_data_o.opened_flow ||
            exp_r.flow_packet_count !== out_data_o.flow_packet_count ||
            exp_r.status !== out_data_o.status) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p actual %p", exp_r, out_data_o);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    @(posedge rst_ni);
    while (!(stim_done && pending_items.size() == 0 && !in_valid_i &&
             expected_results.size() == 0) && cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
    end else begin
      repeat (600) @(posedge clk_i);
      if (mismatches == 0 && expected_results.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
